// File: rtl/lzss_decompressor_unit_macros.svh
// ----------------------------------------------------------------------------
// LZSS decompressor assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LZSS_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZSS_DECOMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LZD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzss decompressor: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define LZD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzss decompressor: next-cycle check failed");

`endif

// File: rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants, command codes and interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int LEN_W      = 32;
  localparam int CNT_W      = 5;   // copy length 2..17

  localparam logic [1:0] HDR_LAST_INDEX   = 2'd3;
  localparam logic [3:0] TOKENS_PER_GROUP = 4'd8;
  localparam logic [4:0] COPY_BIAS        = 5'd2;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LITERAL = 2'd1,
    CMD_PAIR    = 2'd2
  } cmd_kind_t;

  // Work handed from the parser to the copy engine.
  typedef struct packed {
    logic               valid;
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic [HIST_AW-1:0] offset;
    logic [3:0]         len_code;
  } cmd_t;

  // One result byte offered by the copy engine.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
    logic       error;
  } result_t;

endpackage

// File: rtl/lzd_parser.sv
// ----------------------------------------------------------------------------
// LZSS stream parser
// Splits the compressed byte stream into header, flag and token bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzd_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last,
  output lzd_pkg::cmd_t                cmd,
  output logic [lzd_pkg::LEN_W-1:0]    expected_length
);
  import lzd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_PAIR_LOW
  } phase_t;

  phase_t     phase;
  logic [1:0] header_index;
  logic [7:0] flag_shift;
  logic [3:0] token_count;
  logic [7:0] pair_high;
  logic [3:0] token_count_inc;

  assign token_count_inc = token_count + 4'd1;

  always_comb begin
    cmd          = '0;
    cmd.kind     = CMD_LITERAL;
    cmd.data     = in_byte;
    cmd.offset   = {pair_high, in_byte[7:4]};
    cmd.len_code = in_byte[3:0];
    unique case (phase)
      PH_HEADER: begin
        cmd.kind  = CMD_RESTART;
        cmd.valid = accept && (header_index == HDR_LAST_INDEX);
      end
      PH_FLAG: begin
        cmd.valid = 1'b0;
      end
      PH_TOKEN: begin
        cmd.valid = accept && !flag_shift[7];
      end
      PH_PAIR_LOW: begin
        cmd.kind  = CMD_PAIR;
        cmd.valid = accept;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= '0;
      expected_length <= '0;
      flag_shift      <= '0;
      token_count     <= '0;
      pair_high       <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          expected_length <= {expected_length[LEN_W-9:0], in_byte};
          header_index    <= header_index + 2'd1;
          if (header_index == HDR_LAST_INDEX) begin
            token_count <= '0;
            flag_shift  <= '0;
            phase       <= PH_FLAG;
          end
        end
        PH_FLAG: begin
          flag_shift  <= in_byte;
          token_count <= '0;
          phase       <= PH_TOKEN;
        end
        PH_TOKEN: begin
          flag_shift  <= {flag_shift[6:0], 1'b0};
          token_count <= token_count_inc;
          if (flag_shift[7]) begin
            pair_high <= in_byte;
            phase     <= PH_PAIR_LOW;
          end else begin
            phase <= (token_count_inc >= TOKENS_PER_GROUP) ? PH_FLAG : PH_TOKEN;
          end
        end
        PH_PAIR_LOW: begin
          phase <= (token_count >= TOKENS_PER_GROUP) ? PH_FLAG : PH_TOKEN;
        end
      endcase
      // The final byte is handled normally, then the parser waits for a header.
      if (in_last) begin
        phase        <= PH_HEADER;
        header_index <= '0;
        token_count  <= '0;
      end
    end
  end

endmodule

// File: rtl/lzd_copy_engine.sv
// ----------------------------------------------------------------------------
// LZSS copy engine
// Owns the history ring and emits literal, copied and error result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzd_copy_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  lzd_pkg::cmd_t                cmd,
  input  logic [lzd_pkg::LEN_W-1:0]    expected_length,
  input  logic                         res_ready,
  output lzd_pkg::result_t             res,
  output logic                         idle
);
  import lzd_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_EMIT
  } eng_state_t;

  eng_state_t         state;
  logic [HIST_AW-1:0] wp;
  logic [LEN_W-1:0]   produced;
  logic [HIST_AW-1:0] offset;
  logic [CNT_W-1:0]   remaining;
  logic               is_err;
  logic               from_ring;
  logic [7:0]         lit_byte;
  logic [7:0]         rd_data;
  logic [7:0]         ring [HIST_DEPTH];

  logic [LEN_W-1:0]   produced_inc;
  logic               at_limit;
  logic               bad_offset;
  logic               hits_end;
  logic [7:0]         emit_byte;
  logic               fire;

  assign produced_inc = produced + {{(LEN_W-1){1'b0}}, 1'b1};
  assign at_limit     = produced >= expected_length;
  assign bad_offset   = (cmd.offset == '0) ||
                        ({{(LEN_W-HIST_AW){1'b0}}, cmd.offset} > produced);
  assign hits_end     = produced_inc == expected_length;
  assign emit_byte    = from_ring ? rd_data : lit_byte;
  assign fire         = (state == E_EMIT) && res_ready;
  assign idle         = state == E_IDLE;

  always_comb begin
    res.valid      = state == E_EMIT;
    res.data       = is_err ? 8'd0 : emit_byte;
    res.stream_end = !is_err && hits_end;
    res.error      = is_err;
    res.run_last   = is_err || !from_ring || (remaining == 5'd1) || hits_end;
  end

  // History ring: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (fire && !is_err) begin
      ring[wp] <= emit_byte;
    end
    if (state == E_READ) begin
      rd_data <= ring[wp - offset];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      wp        <= '0;
      produced  <= '0;
      offset    <= '0;
      remaining <= '0;
      is_err    <= 1'b0;
      from_ring <= 1'b0;
      lit_byte  <= '0;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (cmd.valid) begin
            lit_byte  <= cmd.data;
            offset    <= cmd.offset;
            remaining <= {1'b0, cmd.len_code} + COPY_BIAS;
            is_err    <= 1'b0;
            from_ring <= 1'b0;
            unique case (cmd.kind)
              CMD_RESTART: begin
                wp       <= '0;
                produced <= '0;
              end
              CMD_LITERAL: begin
                if (!at_limit) begin
                  state <= E_EMIT;
                end
              end
              CMD_PAIR: begin
                priority if (bad_offset) begin
                  is_err <= 1'b1;
                  state  <= E_EMIT;
                end else if (!at_limit) begin
                  from_ring <= 1'b1;
                  state     <= E_READ;
                end
              end
            endcase
          end
        end
        E_READ: begin
          state <= E_EMIT;
        end
        E_EMIT: begin
          if (fire) begin
            if (!is_err) begin
              wp       <= wp + {{(HIST_AW-1){1'b0}}, 1'b1};
              produced <= produced_inc;
            end
            remaining <= remaining - 5'd1;
            state     <= (from_ring && !res.run_last) ? E_READ : E_IDLE;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/lzss_decompressor_unit.sv
// ----------------------------------------------------------------------------
// LZSS decompressor unit
// Decodes a 12-bit offset, 4-bit length LZSS byte stream into plain bytes.
//
// Input: one compressed byte per transfer on s_axis; s_axis_tlast marks the
// final byte of a stream, after which a new 4-byte length header is expected.
// Output: one result byte per transfer on m_axis; m_axis_tlast marks the last
// result caused by one input byte, tuser flags the stream end and errors.
// Header, flag and pair-first bytes produce no output. Before the expected length
// is reached, a literal produces one byte and a pair 2 to 17 copied bytes,
// stopping at the expected length; once it is reached, literals and valid pairs
// produce nothing. A pair with a bad offset produces one error result. Each
// copied byte is a registered read of the history ring, then a write to it. A
// new input byte is taken only after the engine has finished the last one.
// Reset clears the parser, the engine and the output valid; the ring needs no
// clearing, because the offset check keeps reads inside bytes written in this
// stream. When the receiver stalls, the result waits in the output register and
// the engine holds its byte, so no input is taken until the copy can go on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_decompressor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // out_run_last
  output logic [1:0] m_axis_tuser    // [0] out_stream_end, [1] out_error
);
  import lzd_pkg::*;

  `include "lzss_decompressor_unit_macros.svh"

  cmd_t             cmd;
  result_t          eng_res;
  logic [LEN_W-1:0] expected_length;
  logic             eng_idle;
  logic             in_accept;
  logic             out_free;
  logic             out_load;

  // The parser only takes a byte while the engine has nothing in flight, so
  // counters and the ring are never touched by two tokens at once.
  assign s_axis_tready = eng_idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = eng_res.valid && out_free;

  lzd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (in_accept),
    .in_byte         (s_axis_tdata),
    .in_last         (s_axis_tlast),
    .cmd             (cmd),
    .expected_length (expected_length)
  );

  lzd_copy_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .expected_length (expected_length),
    .res_ready       (out_free),
    .res             (eng_res),
    .idle            (eng_idle)
  );

  // Output register: decouples the engine from a stalling receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= eng_res.data;
      m_axis_tlast <= eng_res.run_last;
      m_axis_tuser <= {eng_res.error, eng_res.stream_end};
    end
  end

  // An error result is a lone zero byte that ends its run and never ends the stream.
  `LZD_ASSERT_SAME(a_error_shape, m_axis_tvalid && m_axis_tuser[1],
                   (m_axis_tdata == 8'd0) && !m_axis_tuser[0] && m_axis_tlast)

  // The byte that completes the stream is always the last of its run.
  `LZD_ASSERT_SAME(a_end_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

  // An input transfer only happens while the engine offers no result.
  `LZD_ASSERT_SAME(a_accept_quiet, in_accept, !eng_res.valid)

endmodule
